>>> rtl/stream_mode_finder_macros.svh
// Assertion macros for the stream mode finder.
// Included by the RTL files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef STREAM_MODE_FINDER_MACROS_SVH
`define STREAM_MODE_FINDER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/smf_pkg.sv
// Shared constants and types of the stream mode finder.
// No dependencies; used by smf_cell, smf_reduce and stream_mode_finder.
package smf_pkg;

  localparam int VALUE_W       = 32;
  localparam int TOP_COUNT_W   = 7;
  localparam int DEF_MAX_ITEMS = 64;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic take;   // a value is offered for matching or allocation
    logic shift;  // every cell loads its upper neighbor's contents
  } smf_ctrl_t;

endpackage

>>> rtl/stream_mode_finder.sv
// Top level of the stream mode finder: chain of table cells, head reducer and output register.
// Depends on smf_pkg, smf_cell, smf_reduce and stream_mode_finder_macros.svh.
//
//   channel  direction  payload (tdata low bit up)                 side bands
//   in_      slave      value[31:0]                                 tlast = last of set
//   out_     master     top_count[6:0], mode_value[38:7], 0[39]     tuser = overflowed
//
// While a set is being collected one value is taken every cycle; every cell compares it at once.
// After the transfer with tlast the chain shifts toward its head one cell per cycle, and the
// input stalls until every distinct value of the set has passed the head and the result is loaded.
// The drain also empties the table. A result waiting in the output register does not stop
// collection of the next set; only a second result waits until the first is taken.
// Reset clears the valid bits, the item counter and state at once; no clearing pass is needed.
module stream_mode_finder #(
  parameter int MAX_ITEMS = smf_pkg::DEF_MAX_ITEMS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [smf_pkg::VALUE_W-1:0]              in_tdata,   // value[31:0]
  input  logic                                     in_tlast,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [39:0]                              out_tdata,  // top_count, mode_value, zero
  output logic                                     out_tuser   // overflowed
);
  import smf_pkg::*;

  `include "stream_mode_finder_macros.svh"

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                       state_r, state_nxt;
  logic [CNT_W-1:0]           items_r, items_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       ovf_hold_r, ovf_hold_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [TOP_COUNT_W-1:0]     out_count_r, out_count_nxt;
  logic signed [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                       out_ovf_r, out_ovf_nxt;

  logic                       in_xfer;
  logic                       full;
  logic                       drain_done;
  logic                       hit_any;
  smf_ctrl_t                  ctrl;
  logic signed [VALUE_W-1:0]  in_value;

  logic [MAX_ITEMS-1:0]       cell_valid;
  logic [MAX_ITEMS-1:0]       cell_hit;
  logic signed [VALUE_W-1:0]  cell_value [MAX_ITEMS];
  logic [CNT_W-1:0]           cell_count [MAX_ITEMS];

  logic signed [VALUE_W-1:0]  best_value;
  logic [CNT_W-1:0]           best_count;
  logic [TOP_COUNT_W+CNT_W-1:0] best_count_ext;

  assign in_value   = $signed(in_tdata);
  assign in_tready  = (state_r == ST_FILL);
  assign in_xfer    = in_tvalid && in_tready;
  assign full       = (items_r == CNT_W'(MAX_ITEMS));
  assign hit_any    = |cell_hit;
  assign ctrl.take  = in_xfer && !full;
  assign ctrl.shift = (state_r == ST_DRAIN) && cell_valid[0];
  assign drain_done = (state_r == ST_DRAIN) && !cell_valid[0] && (!out_valid_r || out_tready);

  // Cell 0 sits at the head; each cell loads from the next one up when the chain shifts.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                       prev_v;
    logic                       nb_v;
    logic signed [VALUE_W-1:0]  nb_val;
    logic [CNT_W-1:0]           nb_cnt;

    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = cell_valid[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign nb_v   = 1'b0;
      assign nb_val = '0;
      assign nb_cnt = '0;
    end else begin : g_link
      assign nb_v   = cell_valid[i+1];
      assign nb_val = cell_value[i+1];
      assign nb_cnt = cell_count[i+1];
    end

    smf_cell #(
      .CNT_W(CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .in_value  (in_value),
      .hit_any   (hit_any),
      .prev_valid(prev_v),
      .nb_valid  (nb_v),
      .nb_value  (nb_val),
      .nb_count  (nb_cnt),
      .valid     (cell_valid[i]),
      .value     (cell_value[i]),
      .count     (cell_count[i]),
      .hit       (cell_hit[i])
    );
  end

  smf_reduce #(
    .CNT_W(CNT_W)
  ) u_reduce (
    .clk       (clk),
    .clear     (in_xfer && in_tlast),
    .step      (ctrl.shift),
    .head_value(cell_value[0]),
    .head_count(cell_count[0]),
    .best_value(best_value),
    .best_count(best_count)
  );

  assign best_count_ext = {{TOP_COUNT_W{1'b0}}, best_count};

  always_comb begin
    state_nxt     = state_r;
    items_nxt     = items_r;
    ovf_nxt       = ovf_r;
    ovf_hold_nxt  = ovf_hold_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_value_nxt = out_value_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_FILL: begin
        if (in_xfer) begin
          if (in_tlast) begin
            // The flag for this set is kept aside; counters restart for the next set.
            ovf_hold_nxt = ovf_r || full;
            ovf_nxt      = 1'b0;
            items_nxt    = '0;
            state_nxt    = ST_DRAIN;
          end else if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            items_nxt = items_r + CNT_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = best_count_ext[TOP_COUNT_W-1:0];
          out_value_nxt = best_value;
          out_ovf_nxt   = ovf_hold_r;
          state_nxt     = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      items_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      items_r     <= items_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_hold_r  <= ovf_hold_nxt;
    out_count_r <= out_count_nxt;
    out_value_r <= out_value_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_value_r, out_count_r};
  assign out_tuser  = out_ovf_r;

  // Occupied cells always form a solid run starting at the head.
  `SMF_ASSERT_NOW(a_cells_contiguous, 1'b1, ((cell_valid + 1'b1) & cell_valid) == '0, "table cells not contiguous")
  // Table entries are distinct, so an offered value matches at most one cell.
  `SMF_ASSERT_NOW(a_single_hit, in_xfer, $onehot0(cell_hit), "value matched more than one cell")
  // A set cannot hold more distinct values than items taken.
  `SMF_ASSERT_NOW(a_entries_bounded, state_r == ST_FILL, $countones(cell_valid) <= items_r, "more entries than items taken")
  // A finished drain always has a winner with a nonzero count.
  `SMF_ASSERT_NOW(a_result_nonzero, drain_done, best_count != '0, "result loaded with zero count")
  // Loading a result leaves the table empty for the next set.
  `SMF_ASSERT_NEXT(a_empty_after_drain, drain_done, cell_valid == '0, "table not empty after drain")

endmodule

>>> rtl/smf_cell.sv
// One cell of the value table: a distinct value, its occurrence count and a valid bit.
// Depends on smf_pkg.
module smf_cell #(
  parameter int CNT_W = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smf_pkg::smf_ctrl_t                  ctrl,
  input  logic signed [smf_pkg::VALUE_W-1:0]  in_value,
  input  logic                                hit_any,
  input  logic                                prev_valid,
  input  logic                                nb_valid,
  input  logic signed [smf_pkg::VALUE_W-1:0]  nb_value,
  input  logic [CNT_W-1:0]                    nb_count,
  output logic                                valid,
  output logic signed [smf_pkg::VALUE_W-1:0]  value,
  output logic [CNT_W-1:0]                    count,
  output logic                                hit
);
  import smf_pkg::*;

  logic                       valid_r, valid_nxt;
  logic signed [VALUE_W-1:0]  value_r, value_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       alloc;

  assign hit   = valid_r && (value_r == in_value);
  // Cells fill from the head, so the first empty cell takes a value nobody matched.
  assign alloc = !valid_r && prev_valid && !hit_any;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    count_nxt = count_r;
    if (ctrl.shift) begin
      valid_nxt = nb_valid;
      value_nxt = nb_value;
      count_nxt = nb_count;
    end else if (ctrl.take) begin
      if (hit) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (alloc) begin
        valid_nxt = 1'b1;
        value_nxt = in_value;
        count_nxt = CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    count_r <= count_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;
  assign count = count_r;

endmodule

>>> rtl/smf_reduce.sv
// Running best-entry tracker at the head of the chain: highest count, smallest value on a tie.
// Depends on smf_pkg.
module smf_reduce #(
  parameter int CNT_W = 7
) (
  input  logic                                clk,
  input  logic                                clear,
  input  logic                                step,
  input  logic signed [smf_pkg::VALUE_W-1:0]  head_value,
  input  logic [CNT_W-1:0]                    head_count,
  output logic signed [smf_pkg::VALUE_W-1:0]  best_value,
  output logic [CNT_W-1:0]                    best_count
);
  import smf_pkg::*;

  logic signed [VALUE_W-1:0]  best_value_r, best_value_nxt;
  logic [CNT_W-1:0]           best_count_r, best_count_nxt;
  logic                       better;

  assign better = (head_count > best_count_r) ||
                  ((head_count == best_count_r) && (head_value < best_value_r));

  always_comb begin
    best_value_nxt = best_value_r;
    best_count_nxt = best_count_r;
    if (clear) begin
      best_value_nxt = '0;
      best_count_nxt = '0;
    end else if (step && better) begin
      best_value_nxt = head_value;
      best_count_nxt = head_count;
    end
  end

  always_ff @(posedge clk) begin
    best_value_r <= best_value_nxt;
    best_count_r <= best_count_nxt;
  end

  assign best_value = best_value_r;
  assign best_count = best_count_r;

endmodule
